### rtl/core/palette_recolor_alpha_blend_defines.svh
// Assertion macros shared by the palette recolor blend RTL.
`ifndef PALETTE_RECOLOR_ALPHA_BLEND_DEFINES_SVH
`define PALETTE_RECOLOR_ALPHA_BLEND_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PRAB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("prab: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PRAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("prab: next-cycle check failed");

`endif

### rtl/core/prab_pkg.sv
// Package: types, constants and helpers of the palette recolor blend.
`default_nettype none

package prab_pkg;

  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COLOR_W    = NUM_CH * CHAN_W;
  localparam int unsigned PROD_W     = 2 * CHAN_W;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned VAL_W      = 10;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_THREE = 2'd2;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [VAL_W-1:0]   val_t;

  // Exact floor(x / 255) for x up to 3 * 255 * 255: x>>8 underestimates, and
  // the remainder left over stays under 4 * 255, so three compares finish it.
  function automatic val_t div255(input sum_t x);
    val_t        q0;
    logic [10:0] r;
    logic [1:0]  adj;
    q0  = x[SUM_W-1:CHAN_W];
    r   = {3'b000, x[CHAN_W-1:0]} + {1'b0, q0};
    adj = 2'(r >= 11'd255) + 2'(r >= 11'd510) + 2'(r >= 11'd765);
    return q0 + {8'b0, adj};
  endfunction

endpackage

`default_nettype wire

### rtl/core/prab_in_if.sv
// Interface: pixel request channel (base mask pixel plus emblem pixel).
`default_nettype none

interface prab_in_if
  import prab_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t base_red;
  chan_t base_green;
  chan_t base_blue;
  logic  overlay_present;
  chan_t overlay_red;
  chan_t overlay_green;
  chan_t overlay_blue;
  chan_t overlay_alpha;

  modport source (
    output valid, base_red, base_green, base_blue, overlay_present,
           overlay_red, overlay_green, overlay_blue, overlay_alpha,
    input  ready
  );

  modport sink (
    input  valid, base_red, base_green, base_blue, overlay_present,
           overlay_red, overlay_green, overlay_blue, overlay_alpha,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/prab_out_if.sv
// Interface: recolored pixel result channel.
`default_nettype none

interface prab_out_if
  import prab_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;

  modport source (
    output valid, out_red, out_green, out_blue,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/palette_recolor_alpha_blend.sv
// Top level: five-stage palette recolor with alpha-over blend.
//
//  channel   dir  handshake          payload
//  in_px     in   valid/ready        base RGB, overlay_present, overlay RGBA
//  out_px    out  valid/ready        out_red, out_green, out_blue
//  cfg_*     in   cfg_we only        cfg_index (2b), cfg_wdata (24b)
//
// One pixel enters per cycle unless out_px stalls; each request moves through the
// s1-s4 registers to the output register. The depth is set by the multiply, sum,
// divide, blend-multiply and divide-and-select stages, each one register deep.
// Reset (rst_n low, synchronous) empties every stage and clears the palette.
// A stall on out_px freezes the whole pipe in place; in_px.ready follows it.
`default_nettype none

`include "palette_recolor_alpha_blend_defines.svh"

module palette_recolor_alpha_blend
  import prab_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  prab_in_if.sink                   in_px,
  prab_out_if.source                out_px,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_wdata
);

  // ---------------------------------------------------------------------
  // Palette registers
  // ---------------------------------------------------------------------
  color_t color_one_r, color_two_r, color_three_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_one_r   <= '0;
      color_two_r   <= '0;
      color_three_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOR_ONE:   color_one_r   <= cfg_wdata;
        REG_COLOR_TWO:   color_two_r   <= cfg_wdata;
        REG_COLOR_THREE: color_three_r <= cfg_wdata;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: every stage advances together unless the output
  // register holds a result that is not being taken.
  // ---------------------------------------------------------------------
  logic pipe_en;
  logic out_valid_r;

  assign pipe_en     = !out_valid_r || out_px.ready;
  assign in_px.ready = pipe_en;

  // ---------------------------------------------------------------------
  // Stage 1: inverted-mask products and overlay products
  // ---------------------------------------------------------------------
  chan_t                                   inv_r, inv_g, inv_b;
  chan_t [NUM_CH-1:0]                      ovr_chan;
  prod_t [NUM_CH-1:0][NUM_CH-1:0]          s1_prod_nxt;
  prod_t [NUM_CH-1:0]                      s1_ovr_nxt;

  logic                                    s1_valid_r;
  prod_t [NUM_CH-1:0][NUM_CH-1:0]          s1_prod_r;
  prod_t [NUM_CH-1:0]                      s1_ovr_r;
  chan_t                                   s1_inv_a_r;
  logic                                    s1_present_r;

  assign inv_r = ~in_px.base_red;
  assign inv_g = ~in_px.base_green;
  assign inv_b = ~in_px.base_blue;

  assign ovr_chan[0] = in_px.overlay_red;
  assign ovr_chan[1] = in_px.overlay_green;
  assign ovr_chan[2] = in_px.overlay_blue;

  // Channel c sits at bits [23-8c -: 8] of each palette color.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s1_prod_nxt[c][0] = PROD_W'(inv_g) * PROD_W'(color_one_r[COLOR_W-1-CHAN_W*c -: CHAN_W]);
      s1_prod_nxt[c][1] = PROD_W'(inv_r) * PROD_W'(color_two_r[COLOR_W-1-CHAN_W*c -: CHAN_W]);
      s1_prod_nxt[c][2] = PROD_W'(inv_b) *
                          PROD_W'(color_three_r[COLOR_W-1-CHAN_W*c -: CHAN_W]);
      s1_ovr_nxt[c]     = PROD_W'(ovr_chan[c]) * PROD_W'(in_px.overlay_alpha);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sum the three weighted colors, divide the overlay term
  // ---------------------------------------------------------------------
  sum_t  [NUM_CH-1:0] s2_sum_nxt;
  chan_t [NUM_CH-1:0] s2_ovq_nxt;

  logic               s2_valid_r;
  sum_t  [NUM_CH-1:0] s2_sum_r;
  chan_t [NUM_CH-1:0] s2_ovq_r;
  chan_t              s2_inv_a_r;
  logic               s2_present_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s2_sum_nxt[c] = SUM_W'(s1_prod_r[c][0]) + SUM_W'(s1_prod_r[c][1]) +
                      SUM_W'(s1_prod_r[c][2]);
      // overlay * alpha / 255 never exceeds 255
      s2_ovq_nxt[c] = CHAN_W'(div255(SUM_W'(s1_ovr_r[c])));
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: recolor value = sum / 255 (up to 765)
  // ---------------------------------------------------------------------
  val_t  [NUM_CH-1:0] s3_val_nxt;

  logic               s3_valid_r;
  val_t  [NUM_CH-1:0] s3_val_r;
  chan_t [NUM_CH-1:0] s3_ovq_r;
  chan_t              s3_inv_a_r;
  logic               s3_present_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s3_val_nxt[c] = div255(s2_sum_r[c]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: under-layer blend term value * (255 - alpha)
  // ---------------------------------------------------------------------
  sum_t  [NUM_CH-1:0] s4_bprod_nxt;

  logic               s4_valid_r;
  sum_t  [NUM_CH-1:0] s4_bprod_r;
  chan_t [NUM_CH-1:0] s4_val_lo_r;
  chan_t [NUM_CH-1:0] s4_ovq_r;
  logic               s4_present_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s4_bprod_nxt[c] = SUM_W'(s3_val_r[c]) * SUM_W'(s3_inv_a_r);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: divide, add the overlay term, pick, keep the low byte
  // ---------------------------------------------------------------------
  chan_t [NUM_CH-1:0] out_chan_nxt;
  chan_t [NUM_CH-1:0] out_chan_r;
  val_t  [NUM_CH-1:0] blend_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      blend_q[c]      = div255(s4_bprod_r[c]);
      out_chan_nxt[c] = s4_present_r ? CHAN_W'(blend_q[c] + VAL_W'(s4_ovq_r[c]))
                                     : s4_val_lo_r[c];
    end
  end

  // ---------------------------------------------------------------------
  // Valid bits: cleared by reset, advance with the pipe
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r  <= in_px.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // Payload registers: hold on stall, no reset needed.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_prod_r    <= s1_prod_nxt;
      s1_ovr_r     <= s1_ovr_nxt;
      s1_inv_a_r   <= CHAN_MAX - in_px.overlay_alpha;
      s1_present_r <= in_px.overlay_present;

      s2_sum_r     <= s2_sum_nxt;
      s2_ovq_r     <= s2_ovq_nxt;
      s2_inv_a_r   <= s1_inv_a_r;
      s2_present_r <= s1_present_r;

      s3_val_r     <= s3_val_nxt;
      s3_ovq_r     <= s2_ovq_r;
      s3_inv_a_r   <= s2_inv_a_r;
      s3_present_r <= s2_present_r;

      s4_bprod_r   <= s4_bprod_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        s4_val_lo_r[c] <= s3_val_r[c][CHAN_W-1:0];
      end
      s4_ovq_r     <= s3_ovq_r;
      s4_present_r <= s3_present_r;

      out_chan_r   <= out_chan_nxt;
    end
  end

  assign out_px.valid     = out_valid_r;
  assign out_px.out_red   = out_chan_r[0];
  assign out_px.out_green = out_chan_r[1];
  assign out_px.out_blue  = out_chan_r[2];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `PRAB_ASSERT_NEXT(a_accept_enters_s1, clk, rst_n, in_px.valid && in_px.ready, s1_valid_r)
  `PRAB_ASSERT_NEXT(a_stall_holds_mid, clk, rst_n, !pipe_en, $stable(s3_valid_r) && $stable(s3_val_r))
  `PRAB_ASSERT_NEXT(a_s4_reaches_out, clk, rst_n, s4_valid_r && pipe_en, out_valid_r)
  `PRAB_ASSERT_SAME(a_recolor_range, clk, rst_n, s3_valid_r, (s3_val_r[0] <= 10'd765) && (s3_val_r[2] <= 10'd765))

endmodule

`default_nettype wire
